[hdl/mptw_pkg.sv]
// Shared constants and types for the multilevel page table walker.
`timescale 1ns / 1ps
package mptw_pkg;

	localparam int unsigned NUM_FRAMES  = 64;
	localparam int unsigned LEVELS      = 5;
	localparam int unsigned INDEX_BITS  = 9;

	localparam int unsigned FRAME_BITS  = $clog2(NUM_FRAMES);
	localparam int unsigned ADDR_BITS   = FRAME_BITS + INDEX_BITS;
	localparam int unsigned STORE_DEPTH = NUM_FRAMES << INDEX_BITS;
	localparam int unsigned LVL_BITS    = $clog2(LEVELS + 1);

	localparam int unsigned ENTRY_W     = 64;
	localparam int unsigned PAGE_SHIFT  = 12;
	localparam int unsigned VPN_W       = LEVELS * INDEX_BITS;
	localparam int unsigned PPN_W       = ENTRY_W - PAGE_SHIFT;
	localparam int unsigned OP_W        = 2;
	localparam int unsigned ROOT_W      = 6;
	localparam int unsigned FREE_W      = 7;
	localparam int unsigned PADDR_W     = 3;
	localparam int unsigned PDATA_W     = 32;

	// Register indexes on the configuration port.
	localparam logic REG_ROOT_FRAME = 1'b0;
	localparam logic REG_FIRST_FREE = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY = 2'd0,
		OP_MAP   = 2'd1,
		OP_UNMAP = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

endpackage

[hdl/mptw_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module mptw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/multilevel_page_table_walker.sv]
// Top level of the five-level radix page table walker with its frame store.
`timescale 1ns / 1ps
// The walker keeps a radix page table in an internal frame store and serves
// one request per input transfer: a query, a map or an unmap of one vpn.
// Requests arrive on the in_valid/in_ready channel with op, vpn and ppn, and
// each produces exactly one result transfer on out_valid/out_ready carrying
// found, result_ppn and error. The root frame and the allocator start point
// are to be written through the APB-style port only while no request is in
// flight; the block itself does not enforce this. All table accesses go
// through one memory with a registered read, so each level has a read
// state that presents the address and a check state that checks the returned
// entry and, for a map, writes a fresh interior entry or the leaf. A full walk
// passes both states at every level before the result register is loaded,
// and in_ready returns when the result moves into that register. A walk that
// misses early is shorter, and an unused op code goes straight to the result
// register without a table read. One request is worked on at a time.
// After reset the block sweeps all 32768 entries of the store to zero, one
// entry per cycle, and holds in_ready low meanwhile; register writes are still
// taken. A result waits in the output register while the receiver stalls,
// and the next request may be accepted and walked in the meantime; its own
// result is held back until the output register is free.
module multilevel_page_table_walker (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mptw_pkg::PADDR_W-1:0]   paddr,
	input  logic [mptw_pkg::PDATA_W-1:0]   pwdata,
	output logic [mptw_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	// Request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mptw_pkg::OP_W-1:0]      op,
	input  logic [mptw_pkg::VPN_W-1:0]     vpn,
	input  logic [mptw_pkg::PPN_W-1:0]     ppn,
	// Result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [mptw_pkg::PPN_W-1:0]     result_ppn,
	output logic                           error
);

	import mptw_pkg::*;

	// Configuration registers and the bump allocator.
	logic [ROOT_W-1:0]     root_frame_q;
	logic [FREE_W-1:0]     first_free_q;
	logic [FREE_W-1:0]     next_free_q;

	// Sequencer state.
	state_t                state_q;
	logic [ADDR_BITS-1:0]  clr_q;
	logic [LVL_BITS-1:0]   lvl_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [ADDR_BITS-1:0]  addr_q;

	// The request being walked. The vpn shifts up by one index per level,
	// so the current index always sits in the top bits.
	op_t                   op_q;
	logic [VPN_W-1:0]      vpn_q;
	logic [PPN_W-1:0]      ppn_q;

	// Result waiting for the output register.
	logic                  res_found_q;
	logic [PPN_W-1:0]      res_ppn_q;
	logic                  res_error_q;

	// Output register.
	logic                  out_valid_q;
	logic                  found_q;
	logic [PPN_W-1:0]      result_ppn_q;
	logic                  error_q;

	// Memory port.
	logic                  mem_we;
	logic [ADDR_BITS-1:0]  mem_waddr;
	logic [ENTRY_W-1:0]    mem_wdata;
	logic                  mem_re;
	logic [ADDR_BITS-1:0]  mem_raddr;
	logic [ENTRY_W-1:0]    mem_rdata;

	logic                  cfg_write;
	logic                  in_xfer;
	logic                  out_xfer;
	logic                  last_level;
	logic                  entry_valid;
	logic                  out_of_frames;
	logic [INDEX_BITS-1:0] cur_index;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_ROOT_FRAME: prdata = PDATA_W'(root_frame_q);
			REG_FIRST_FREE: prdata = PDATA_W'(first_free_q);
			default:        prdata = '0;
		endcase
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign in_xfer       = in_valid && in_ready;
	assign out_valid     = out_valid_q;
	assign out_xfer      = out_valid_q && out_ready;
	assign found         = found_q;
	assign result_ppn    = result_ppn_q;
	assign error         = error_q;

	assign cur_index     = vpn_q[VPN_W-1 -: INDEX_BITS];
	assign last_level    = (lvl_q == LVL_BITS'(LEVELS - 1));
	assign entry_valid   = mem_rdata[0];
	assign out_of_frames = (32'(next_free_q) >= NUM_FRAMES);

	// Memory port control. The read address is the current frame and index;
	// writes go either to the sweep address or back to the entry just read.
	always_comb begin
		mem_re    = (state_q == ST_READ);
		mem_raddr = {frame_q, cur_index};
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_CHECK: begin
				if (!last_level) begin
					// A missing interior table gets the next free frame.
					if (!entry_valid && op_q == OP_MAP && !out_of_frames) begin
						mem_we    = 1'b1;
						mem_wdata = (ENTRY_W'(next_free_q[FRAME_BITS-1:0]) << PAGE_SHIFT)
							| ENTRY_W'(1);
					end
				end else begin
					case (op_q)
						OP_MAP: begin
							mem_we    = 1'b1;
							mem_wdata = {ppn_q, {(PAGE_SHIFT-1){1'b0}}, 1'b1};
						end
						OP_UNMAP: begin
							mem_we    = entry_valid;
							mem_wdata = {mem_rdata[ENTRY_W-1:1], 1'b0};
						end
						default: begin
							mem_we = 1'b0;
						end
					endcase
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	mptw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer, configuration registers and allocator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			lvl_q        <= '0;
			root_frame_q <= '0;
			first_free_q <= FREE_W'(1);
			next_free_q  <= FREE_W'(1);
			op_q         <= OP_NONE;
		end else begin
			if (cfg_write) begin
				case (paddr[2])
					REG_ROOT_FRAME: root_frame_q <= pwdata[ROOT_W-1:0];
					REG_FIRST_FREE: begin
						first_free_q <= pwdata[FREE_W-1:0];
						next_free_q  <= pwdata[FREE_W-1:0];
					end
					default: begin
						root_frame_q <= root_frame_q;
					end
				endcase
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_BITS'(1);
					if (clr_q == ADDR_BITS'(STORE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						op_q  <= op_t'(op);
						lvl_q <= '0;
						if (op_t'(op) == OP_NONE) begin
							state_q <= ST_RESP;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (last_level) begin
						state_q <= ST_RESP;
					end else if (entry_valid) begin
						lvl_q   <= lvl_q + LVL_BITS'(1);
						state_q <= ST_READ;
					end else if (op_q == OP_MAP && !out_of_frames) begin
						next_free_q <= next_free_q + FREE_W'(1);
						lvl_q       <= lvl_q + LVL_BITS'(1);
						state_q     <= ST_READ;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk datapath and pending result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					vpn_q       <= vpn;
					ppn_q       <= ppn;
					frame_q     <= FRAME_BITS'(root_frame_q);
					res_found_q <= 1'b0;
					res_ppn_q   <= '0;
					res_error_q <= 1'b0;
				end
			end
			ST_READ: begin
				addr_q <= mem_raddr;
			end
			ST_CHECK: begin
				vpn_q <= vpn_q << INDEX_BITS;
				if (!last_level) begin
					if (entry_valid) begin
						frame_q <= mem_rdata[PAGE_SHIFT +: FRAME_BITS];
					end else if (op_q == OP_MAP) begin
						frame_q     <= next_free_q[FRAME_BITS-1:0];
						res_error_q <= out_of_frames;
					end
				end else begin
					case (op_q)
						OP_QUERY: begin
							res_found_q <= entry_valid;
							res_ppn_q   <= entry_valid ? mem_rdata[ENTRY_W-1:PAGE_SHIFT] : '0;
						end
						OP_MAP: begin
							res_found_q <= 1'b1;
						end
						OP_UNMAP: begin
							res_found_q <= entry_valid;
						end
						default: begin
							res_found_q <= 1'b0;
						end
					endcase
				end
			end
			default: begin
				addr_q <= addr_q;
			end
		endcase
	end

	// Output register: loaded from the pending result when it is free or
	// being emptied in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && (!out_valid_q || out_ready)) begin
			found_q      <= res_found_q;
			result_ppn_q <= res_ppn_q;
			error_q      <= res_error_q;
		end
	end

endmodule
